// ===== src/bsf_pkg.sv =====
// bsf_pkg: shared constants, codes and command/status types of the span finder
// used by bsf_ctrl, bsf_dp, the top level and the checker
`default_nettype none

package bsf_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int ROWS      = 64;
  localparam int WORD_BITS = 64;
  localparam int WORDS     = MAX_CELLS / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WRD_W     = $clog2(WORDS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ADDR_W    = ROW_W + WRD_W;
  localparam int DEPTH     = ROWS * WORDS;
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int POS_W     = CELL_W + 1;
  localparam int REQ_W     = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_NEXT   = 2'd1,
    REQ_AROUND = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SEARCH,
    ST_EXT_R,
    ST_EXT_L,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    W_HOLD,
    W_INC,
    W_DEC,
    W_POS
  } wrd_op_t;

  typedef enum logic [1:0] {
    SB_HOLD,
    SB_HIT,
    SB_POS,
    SB_CARRY
  } sb_op_t;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_CLEAR,
    RES_MISS,
    RES_START_HIT,
    RES_END,
    RES_START_LEFT
  } res_op_t;

  typedef struct packed {
    logic    load;
    logic    clr_we;
    logic    cell_we;
    logic    out_load;
    wrd_op_t wrd_op;
    sb_op_t  sb_op;
    res_op_t res_op;
  } cmd_t;

  typedef struct packed {
    logic pos_ok;
    logic srch_hit;
    logic srch_more;
    logic right_stop;
    logic left_stop;
    logic around;
    logic clr_last;
  } sts_t;

  // index of the lowest set bit
  function automatic logic [BIT_W-1:0] ffs(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (v[k]) idx = BIT_W'(k);
    end
    return idx;
  endfunction

  // index of the highest set bit
  function automatic logic [BIT_W-1:0] fls(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (v[k]) idx = BIT_W'(k);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== src/bsf_ctrl.sv =====
// bsf_ctrl: sequencer of the span finder (clear pass, writes, word scans)
// depends on bsf_pkg; drives bsf_dp through cmd_t, reads sts_t
`default_nettype none

module bsf_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bsf_pkg::REQ_W-1:0]         req_type,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  bsf_pkg::sts_t                     sts,
  output bsf_pkg::cmd_t                     cmd
);
  import bsf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '{load: 1'b0, clr_we: 1'b0, cell_we: 1'b0, out_load: 1'b0,
                   wrd_op: W_HOLD, sb_op: SB_HOLD, res_op: RES_HOLD};
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cmd.sb_op  = SB_POS;
          cmd.res_op = RES_CLEAR;
          case (req_t'(req_type))
            REQ_WRITE:  state_next = sts.pos_ok ? ST_WRITE  : ST_DONE;
            REQ_NEXT:   state_next = sts.pos_ok ? ST_SEARCH : ST_DONE;
            REQ_AROUND: state_next = sts.pos_ok ? ST_EXT_R  : ST_DONE;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_WRITE: begin
        cmd.cell_we = 1'b1;
        state_next  = ST_DONE;
      end
      ST_SEARCH: begin
        if (sts.srch_hit) begin
          cmd.res_op = RES_START_HIT;
          cmd.sb_op  = SB_HIT;
          state_next = ST_EXT_R;
        end else if (sts.srch_more) begin
          cmd.wrd_op = W_INC;
        end else begin
          cmd.res_op = RES_MISS;
          state_next = ST_DONE;
        end
      end
      ST_EXT_R: begin
        if (sts.right_stop) begin
          cmd.res_op = RES_END;
          if (sts.around) begin
            cmd.wrd_op = W_POS;
            cmd.sb_op  = SB_POS;
            state_next = ST_EXT_L;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          cmd.wrd_op = W_INC;
          cmd.sb_op  = SB_CARRY;
        end
      end
      ST_EXT_L: begin
        if (sts.left_stop) begin
          cmd.res_op = RES_START_LEFT;
          state_next = ST_DONE;
        end else begin
          cmd.wrd_op = W_DEC;
          cmd.sb_op  = SB_CARRY;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
    out_valid_next = cmd.out_load | (out_valid & ~out_ready);
  end

endmodule

`default_nettype wire

// ===== src/bsf_dp.sv =====
// bsf_dp: bit map memory, word scan logic, result and output registers
// depends on bsf_pkg; commanded by bsf_ctrl
`default_nettype none

module bsf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bsf_pkg::POS_W-1:0]     cfg_wdata,
  input  logic [bsf_pkg::REQ_W-1:0]     req_type,
  input  logic [bsf_pkg::ROW_W-1:0]     row,
  input  logic [bsf_pkg::POS_W-1:0]     position,
  input  logic                          resident_bit,
  input  logic                          break_bit,
  input  bsf_pkg::cmd_t                 cmd,
  output bsf_pkg::sts_t                 sts,
  output logic                          found,
  output logic [bsf_pkg::CELL_W-1:0]    span_start,
  output logic [bsf_pkg::CELL_W-1:0]    span_end,
  output logic [bsf_pkg::POS_W-1:0]     next_cursor
);
  import bsf_pkg::*;

  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  // word = {break bits, resident bits}
  logic [2*WORD_BITS-1:0] mem [DEPTH];
  logic [2*WORD_BITS-1:0] rd_word;
  logic [2*WORD_BITS-1:0] wr_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   mem_we;

  logic [POS_W-1:0]  cells;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ROW_W-1:0]  row_q;
  logic [ROW_W-1:0]  row_next;
  logic [POS_W-1:0]  pos_q;
  logic              res_bit_q;
  logic              brk_bit_q;
  logic              around_q;
  logic [WRD_W-1:0]  wrd;
  logic [WRD_W-1:0]  wrd_next;
  logic [BIT_W-1:0]  sb;
  logic              carry;

  logic              res_found;
  logic [CELL_W-1:0] res_start;
  logic [CELL_W-1:0] res_end;
  logic [POS_W-1:0]  res_cursor;

  logic [WORD_BITS-1:0] rd_res;
  logic [WORD_BITS-1:0] rd_brk;
  logic [WORD_BITS-1:0] wr_res;
  logic [WORD_BITS-1:0] wr_brk;
  logic [WORD_BITS-1:0] lim;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] stop;
  logic [WORD_BITS-1:0] lfail;
  logic [POS_W-1:0]     base;
  logic                 nextlim;
  logic [BIT_W-1:0]     hit_idx;
  logic [BIT_W-1:0]     right_idx;
  logic [BIT_W-1:0]     left_idx;
  logic [CELL_W-1:0]    right_val;
  logic [CELL_W-1:0]    left_val;
  logic [BIT_W-1:0]     pos_bit;
  logic                 is_query;

  assign rd_res = rd_word[WORD_BITS-1:0];
  assign rd_brk = rd_word[2*WORD_BITS-1:WORD_BITS];

  // scan logic over the word of the current row that was read last cycle
  always_comb begin
    base = {1'b0, wrd, {BIT_W{1'b0}}};
    for (int k = 0; k < WORD_BITS; k++) begin
      lim[k] = {1'b0, wrd, BIT_W'(k)} < cells;
    end
    nextlim = (base + POS_W'(WORD_BITS)) < cells;

    // first resident cell at or after the cursor
    if (wrd == pos_q[BIT_W +: WRD_W]) cand = rd_res & lim & (ONES << pos_q[BIT_W-1:0]);
    else                              cand = rd_res & lim;
    hit_idx = ffs(cand);

    // a cell ends the span when it has a break or its right neighbor is not usable
    stop      = (rd_brk | ~{nextlim, rd_res[WORD_BITS-1:1] & lim[WORD_BITS-1:1]})
                & (ONES << sb);
    right_idx = ffs(stop);
    if (carry && !rd_res[0]) right_val = {wrd - WRD_W'(1), {BIT_W{1'b1}}};
    else                     right_val = {wrd, right_idx};

    // leftward: a cell joins when resident and not broken
    lfail    = ~(rd_res & ~rd_brk) & (carry ? ONES : ~(ONES << sb));
    left_idx = fls(lfail);
    if (lfail != '0) left_val = {wrd, left_idx} + CELL_W'(1);
    else             left_val = {wrd, {BIT_W{1'b0}}};

    // cell write merge
    wr_res = rd_res;
    wr_brk = rd_brk;
    wr_res[pos_q[BIT_W-1:0]] = res_bit_q;
    wr_brk[pos_q[BIT_W-1:0]] = brk_bit_q;
  end

  always_comb begin
    sts.pos_ok     = position < cells;
    sts.srch_hit   = cand != '0;
    sts.srch_more  = nextlim;
    sts.right_stop = (carry & ~rd_res[0]) | (stop != '0);
    sts.left_stop  = (lfail != '0) | (wrd == '0);
    sts.around     = around_q;
    sts.clr_last   = &clr_cnt;
  end

  // word index; the memory is read at the next index so data lines up with wrd
  always_comb begin
    row_next = cmd.load ? row : row_q;
    if (cmd.load) begin
      wrd_next = position[BIT_W +: WRD_W];
    end else begin
      case (cmd.wrd_op)
        W_INC:   wrd_next = wrd + WRD_W'(1);
        W_DEC:   wrd_next = wrd - WRD_W'(1);
        W_POS:   wrd_next = pos_q[BIT_W +: WRD_W];
        default: wrd_next = wrd;
      endcase
    end
    rd_addr = {row_next, wrd_next};
    mem_we  = cmd.clr_we | cmd.cell_we;
    wr_addr = cmd.clr_we ? clr_cnt : {row_q, pos_q[BIT_W +: WRD_W]};
    wr_data = cmd.clr_we ? '0 : {wr_brk, wr_res};
    pos_bit = cmd.load ? position[BIT_W-1:0] : pos_q[BIT_W-1:0];
    is_query = (req_t'(req_type) == REQ_NEXT) || (req_t'(req_type) == REQ_AROUND);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells   <= POS_W'(MAX_CELLS);
      clr_cnt <= '0;
    end else begin
      if (cfg_we) cells <= (cfg_wdata > POS_W'(MAX_CELLS)) ? POS_W'(MAX_CELLS) : cfg_wdata;
      if (cmd.clr_we) clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    wrd <= wrd_next;
    if (cmd.load) begin
      row_q     <= row;
      pos_q     <= position;
      res_bit_q <= resident_bit;
      brk_bit_q <= break_bit;
      around_q  <= req_t'(req_type) == REQ_AROUND;
    end
    case (cmd.sb_op)
      SB_HIT: begin
        sb    <= hit_idx;
        carry <= 1'b0;
      end
      SB_POS: begin
        sb    <= pos_bit;
        carry <= 1'b0;
      end
      SB_CARRY: begin
        sb    <= '0;
        carry <= 1'b1;
      end
      default: ;
    endcase
    case (cmd.res_op)
      RES_CLEAR: begin
        res_found  <= 1'b0;
        res_start  <= '0;
        res_end    <= '0;
        res_cursor <= is_query ? cells : '0;
      end
      RES_MISS: begin
        res_found  <= 1'b0;
        res_start  <= '0;
        res_end    <= '0;
        res_cursor <= cells;
      end
      RES_START_HIT: res_start <= {wrd, hit_idx};
      RES_END: begin
        res_found  <= 1'b1;
        res_end    <= right_val;
        res_cursor <= {1'b0, right_val} + POS_W'(1);
      end
      RES_START_LEFT: res_start <= left_val;
      default: ;
    endcase
    if (cmd.out_load) begin
      found       <= res_found;
      span_start  <= res_start;
      span_end    <= res_end;
      next_cursor <= res_cursor;
    end
  end

endmodule

`default_nettype wire

// ===== src/bitmap_span_finder_core.sv =====
// bitmap_span_finder_core: top level of the resident/break bit map span finder
// depends on bsf_pkg, bsf_ctrl and bsf_dp
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   in       | in_valid / in_ready   | req_type, row, position, resident_bit,
//            |                       | break_bit
//   out      | out_valid / out_ready | found, span_start, span_end, next_cursor
//   cfg      | cfg_we (no wait)      | cfg_wdata -> cells
//
// cells live in 64-cell words, one memory word per row and word index; one word
// is examined per cycle through the single registered read port
// write: accept, read-modify-write, result; next span: accept, a search step per
// word searched, an extend step per word extended right (hit word read in both), result
// span around: accept, a step per word scanned right, a step per word scanned left
// (start word in both), result; up to 16 words each way at 1024 cells
// after reset a clearing pass writes all 1024 memory words, one per cycle;
// in_ready stays low during that pass, cfg writes are taken meanwhile
// one item is in flight at a time; a finished result waits in the output
// register while the next transfer is taken, a full output stalls the result step
`default_nettype none

module bitmap_span_finder_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [bsf_pkg::POS_W-1:0]     cfg_wdata,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsf_pkg::REQ_W-1:0]     req_type,
  input  logic [bsf_pkg::ROW_W-1:0]     row,
  input  logic [bsf_pkg::POS_W-1:0]     position,
  input  logic                          resident_bit,
  input  logic                          break_bit,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [bsf_pkg::CELL_W-1:0]    span_start,
  output logic [bsf_pkg::CELL_W-1:0]    span_end,
  output logic [bsf_pkg::POS_W-1:0]     next_cursor
);
  import bsf_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clear pass, request decode, word scan stepping, output handoff
  bsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: bit map memory, per-word find logic, result registers
  bsf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_type     (req_type),
    .row          (row),
    .position     (position),
    .resident_bit (resident_bit),
    .break_bit    (break_bit),
    .cmd          (cmd),
    .sts          (sts),
    .found        (found),
    .span_start   (span_start),
    .span_end     (span_end),
    .next_cursor  (next_cursor)
  );

endmodule

`default_nettype wire

// ===== src/bsf_checker.sv =====
// bsf_checker: port-level assertions for bitmap_span_finder_core
// depends on bsf_pkg; attached to the top level by the bind below
`default_nettype none

module bsf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          found,
  input logic [bsf_pkg::CELL_W-1:0]    span_start,
  input logic [bsf_pkg::CELL_W-1:0]    span_end,
  input logic [bsf_pkg::POS_W-1:0]     next_cursor
);
  import bsf_pkg::*;

  // a waiting result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(span_start)
      && $stable(span_end) && $stable(next_cursor))
    else $error("result changed while stalled");

  // one request in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a miss carries no span
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> span_start == '0 && span_end == '0)
    else $error("span bounds set without a span");

  // a span is ordered and the cursor sits right after it
  a_span_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> span_start <= span_end
      && next_cursor == ({1'b0, span_end} + POS_W'(1)))
    else $error("span bounds or cursor inconsistent");

endmodule

bind bitmap_span_finder_core bsf_checker u_bsf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .found       (found),
  .span_start  (span_start),
  .span_end    (span_end),
  .next_cursor (next_cursor)
);

`default_nettype wire

// ===== test/tb_bitmap_span_finder_core.sv =====
// tb_bitmap_span_finder_core: self-checking bench for the resident/break span finder
// needs bsf_pkg and bitmap_span_finder_core; holds a local model of both bit maps
`timescale 1ns / 1ps

module tb_bitmap_span_finder_core;
  import bsf_pkg::*;

  // one request as it goes onto the input channel
  typedef struct {
    req_t              kind;
    logic [ROW_W-1:0]  row;
    logic [POS_W-1:0]  position;
    logic              resident_bit;
    logic              break_bit;
  } span_req_t;

  // one result as it comes off the output channel
  typedef struct packed {
    logic              found;
    logic [CELL_W-1:0] span_start;
    logic [CELL_W-1:0] span_end;
    logic [POS_W-1:0]  next_cursor;
  } span_t;

  localparam int HOLD_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [POS_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [REQ_W-1:0]   req_type = '0;
  logic [ROW_W-1:0]   row = '0;
  logic [POS_W-1:0]   position = '0;
  logic               resident_bit = 1'b0;
  logic               break_bit = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic [CELL_W-1:0]  span_start;
  logic [CELL_W-1:0]  span_end;
  logic [POS_W-1:0]   next_cursor;

  // local copy of the block state: both maps plus the cell count register
  bit [MAX_CELLS-1:0] resident_cells [ROWS];
  bit [MAX_CELLS-1:0] break_cells [ROWS];
  int                 cells_cfg = 1024;

  span_req_t pending_reqs [$];
  span_t     expected_spans [$];
  span_req_t offered;

  int  errors = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  settings_used = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  bit  hold_start = 1'b0;
  logic out_hold = 1'b0;

  bitmap_span_finder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .row          (row),
    .position     (position),
    .resident_bit (resident_bit),
    .break_bit    (break_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .span_start   (span_start),
    .span_end     (span_end),
    .next_cursor  (next_cursor)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted result of one request; writes update the local maps
  function automatic span_t apply_request(span_req_t q);
    span_t s;
    int    n;
    int    pos;
    int    r;
    int    left;
    int    right;
    s = '0;
    // counts above the map size behave as the full map
    n = (cells_cfg > MAX_CELLS) ? MAX_CELLS : cells_cfg;
    pos = q.position;
    r = q.row;
    case (q.kind)
      REQ_WRITE: begin
        // writes past the cell count are dropped
        if (pos < n) begin
          resident_cells[r][pos] = q.resident_bit;
          break_cells[r][pos] = q.break_bit;
        end
      end
      REQ_NEXT, REQ_AROUND: begin
        if (pos >= n) begin
          s.next_cursor = POS_W'(n);
        end else begin
          left = pos;
          // next span first skips to a resident cell, span around starts in place
          if (q.kind == REQ_NEXT) begin
            while (left < n && !resident_cells[r][left]) left++;
          end
          if (left >= n) begin
            s.next_cursor = POS_W'(n);
          end else begin
            right = left;
            while (right + 1 < n && resident_cells[r][right + 1] && !break_cells[r][right])
              right++;
            if (q.kind == REQ_AROUND) begin
              while (left > 0 && resident_cells[r][left - 1] && !break_cells[r][left - 1])
                left--;
            end
            s.found = 1'b1;
            s.span_start = CELL_W'(left);
            s.span_end = CELL_W'(right);
            s.next_cursor = POS_W'(right + 1);
          end
        end
      end
      default: ;  // unused code returns all zeros
    endcase
    return s;
  endfunction

  function automatic void check_field(string name, int expected_v, int actual_v);
    if (expected_v != actual_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected_v, actual_v);
      errors++;
    end
  endfunction

  task automatic push_req(req_t kind, int r, int pos, bit res, bit brk);
    span_req_t q;
    q.kind = kind;
    q.row = ROW_W'(r);
    q.position = POS_W'(pos);
    q.resident_bit = res;
    q.break_bit = brk;
    pending_reqs.push_back(q);
  endtask

  // random request aimed at a window of a few hot rows so that spans build up
  function automatic span_req_t random_request(int n, int base);
    span_req_t q;
    int        pick;
    int        w;
    pick = $urandom_range(0, 99);
    if (pick < 50) q.kind = REQ_WRITE;
    else if (pick < 75) q.kind = REQ_NEXT;
    else if (pick < 96) q.kind = REQ_AROUND;
    else q.kind = REQ_NONE;
    if ($urandom_range(0, 3) == 0) q.row = ROW_W'($urandom_range(0, ROWS - 1));
    else q.row = ROW_W'($urandom_range(0, 3) * 21);
    w = (n < 160) ? n : 160;
    if (n == 0 || $urandom_range(0, 19) == 0) q.position = POS_W'($urandom_range(0, 2047));
    else q.position = POS_W'((base + $urandom_range(0, w - 1)) % n);
    q.resident_bit = ($urandom_range(0, 9) < 7);
    q.break_bit = ($urandom_range(0, 9) < 2);
    return q;
  endfunction

  // wait until the block holds nothing and the sender has nothing left
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_spans.size() != 0)
      @(negedge clk);
  endtask

  // cell count writes wait until no request is in flight
  task automatic set_cells(int cells);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= POS_W'(cells);
    @(posedge clk);
    cfg_we <= 1'b0;
    cells_cfg = cells;
    settings_used++;
  endtask

  task automatic run_phase(int cells, int count, bit with_hold);
    int n;
    int base;
    set_cells(cells);
    n = (cells > MAX_CELLS) ? MAX_CELLS : cells;
    base = (n == 0) ? 0 : $urandom_range(0, n - 1);
    for (int k = 0; k < count; k++) pending_reqs.push_back(random_request(n, base));
    if (with_hold) hold_start = 1'b1;
  endtask

  // sender: offers pending requests, predicts each one on its transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_spans.push_back(apply_request(offered));
        items_sent++;
        // idle burst before the next offer
        if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 5);
      end
      // a held offer stays put until its transfer
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          offered = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= offered.kind;
          row <= offered.row;
          position <= offered.position;
          resident_bit <= offered.resident_bit;
          break_bit <= offered.break_bit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_spans.size() == 0) begin
          $error("result transfer with no request waiting");
          errors++;
        end else begin
          span_t e;
          e = expected_spans.pop_front();
          check_field("found", e.found, found);
          check_field("span_start", e.span_start, span_start);
          check_field("span_end", e.span_end, span_end);
          check_field("next_cursor", e.next_cursor, next_cursor);
          results_checked++;
        end
      end
      // short random stalls, plus the long hold-off below
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (out_hold) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 5);
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_start);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // register write lands during the clearing pass
    set_cells(1024);

    // directed: empty row, a broken run at the row start, the row end
    push_req(REQ_NEXT, 0, 0, 0, 0);
    push_req(REQ_WRITE, 5, 0, 1, 0);
    push_req(REQ_WRITE, 5, 1, 1, 1);
    push_req(REQ_WRITE, 5, 2, 1, 0);
    push_req(REQ_WRITE, 5, 3, 1, 0);
    push_req(REQ_WRITE, 5, 1022, 1, 0);
    push_req(REQ_WRITE, 5, 1023, 1, 1);
    push_req(REQ_NEXT, 5, 0, 0, 0);
    push_req(REQ_NEXT, 5, 2, 0, 0);
    push_req(REQ_NEXT, 5, 4, 0, 0);
    push_req(REQ_AROUND, 5, 3, 0, 0);
    push_req(REQ_AROUND, 5, 0, 0, 0);
    // around a cell that is not resident still reports a span
    push_req(REQ_AROUND, 5, 100, 0, 0);
    push_req(REQ_AROUND, 5, 1023, 0, 0);
    // writes and queries at or past the cell count
    push_req(REQ_WRITE, 5, 1024, 1, 1);
    push_req(REQ_WRITE, 63, 2047, 1, 1);
    push_req(REQ_NEXT, 5, 1024, 0, 0);
    push_req(REQ_AROUND, 63, 2047, 1, 1);
    push_req(REQ_NONE, 63, 2047, 1, 1);
    // span crossing a word boundary in the last row
    push_req(REQ_WRITE, 63, 63, 1, 0);
    push_req(REQ_WRITE, 63, 64, 1, 0);
    push_req(REQ_NEXT, 63, 0, 0, 0);
    // clearing the break cell shortens the run at the row start
    push_req(REQ_WRITE, 5, 1, 0, 0);
    push_req(REQ_AROUND, 5, 0, 0, 0);
    push_req(REQ_NEXT, 5, 1, 0, 0);

    // random phases over several cell counts, the extremes among them
    run_phase(1024, 110, 1'b0);
    run_phase(1024, 110, 1'b1);
    run_phase(1, 70, 1'b0);
    run_phase(64, 110, 1'b0);
    run_phase(1000, 110, 1'b0);
    run_phase(0, 40, 1'b0);
    run_phase(2047, 110, 1'b0);
    run_phase(137, 110, 1'b0);
    drain();
    // last stretch runs with no idling on either side
    quiet = 1'b1;
    run_phase(1024, 110, 1'b0);
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d requests and %0d checked results over %0d cell counts,",
             items_sent, results_checked, settings_used);
    $display("with random idling, a long output hold-off and a final stretch at full rate");
    if (errors == 0 && expected_spans.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bsf_pkg.sv
src/bsf_ctrl.sv
src/bsf_dp.sv
src/bitmap_span_finder_core.sv
src/bsf_checker.sv
test/tb_bitmap_span_finder_core.sv
